// ===== hw/rtl/i2cram_pkg.sv =====
package i2cram_pkg;

   localparam int CMD_W       = 2;
   localparam int DEV_ADDR_W  = 7;
   localparam int BYTE_W      = 8;
   localparam int DELAY_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUARTER_DELAY  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_DELAY     = 2'd2;

   localparam logic [DEV_ADDR_W-1:0] DEVICE_ADDRESS_RST = 7'd104;
   localparam logic [DELAY_W-1:0]    QUARTER_DELAY_RST  = 16'd12;
   localparam logic [DELAY_W-1:0]    HALF_DELAY_RST     = 16'd20;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] reg_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              sda_in;
      logic              scl_in;
   } item_type;

   typedef struct packed {
      logic              sda_pull_low;
      logic              scl_pull_low;
      logic              busy_res;
      logic              done_res;
      logic              success;
      logic [BYTE_W-1:0] read_byte;
   } result_type;

endpackage

// ===== hw/rtl/i2cram_req_if.sv =====
interface i2cram_req_if import i2cram_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] reg_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              sda_in;
   logic              scl_in;

   modport source (output valid, output cmd, output reg_addr, output wr_data,
                   output sda_in, output scl_in, input ready);
   modport sink   (input valid, input cmd, input reg_addr, input wr_data,
                   input sda_in, input scl_in, output ready);
endinterface

// ===== hw/rtl/i2cram_rsp_if.sv =====
interface i2cram_rsp_if import i2cram_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              sda_pull_low;
   logic              scl_pull_low;
   logic              busy_res;
   logic              done_res;
   logic              success;
   logic [BYTE_W-1:0] read_byte;

   modport source (output valid, output sda_pull_low, output scl_pull_low,
                   output busy_res, output done_res, output success,
                   output read_byte, input ready);
   modport sink   (input valid, input sda_pull_low, input scl_pull_low,
                   input busy_res, input done_res, input success,
                   input read_byte, output ready);
endinterface

// ===== hw/rtl/i2cram_front.sv =====
module i2cram_front import i2cram_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   i2cram_req_if.sink    req,
   output logic          push_valid,
   input  logic          push_ready,
   output item_type      push_item
);

   logic     stage_valid_ff;
   logic     stage_valid_in;
   item_type stage_item_ff;
   item_type stage_item_in;
   logic     accept;
   logic     drain;
   op_type   op;

   always_comb begin
      case (req.cmd)
         CMD_READ:  op = OP_READ;
         CMD_WRITE: op = OP_WRITE;
         default:   op = OP_TICK;
      endcase
   end

   assign drain     = stage_valid_ff && push_ready;
   assign req.ready = !stage_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (drain) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in         = 1'b1;
         stage_item_in.op       = op;
         stage_item_in.reg_addr = req.reg_addr;
         stage_item_in.wr_data  = req.wr_data;
         stage_item_in.sda_in   = req.sda_in;
         stage_item_in.scl_in   = req.scl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;

endmodule

// ===== hw/rtl/i2cram_queue.sv =====
module i2cram_queue import i2cram_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/i2cram_engine.sv =====
module i2cram_engine import i2cram_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  item_type               item,
   i2cram_rsp_if.source           rsp
);

   typedef enum logic [4:0] {
      PH_IDLE       = 5'd0,
      PH_ST_SCL_HI  = 5'd1,
      PH_ST_SDA_LO  = 5'd2,
      PH_WB_SCL_LO  = 5'd4,
      PH_WB_SDA     = 5'd5,
      PH_WB_SCL_HI  = 5'd6,
      PH_WB_WAIT    = 5'd7,
      PH_AK_SCL_LO  = 5'd8,
      PH_AK_REL     = 5'd9,
      PH_AK_SCL_HI  = 5'd10,
      PH_AK_WAIT    = 5'd11,
      PH_AK_END     = 5'd12,
      PH_RB_SCL_LO  = 5'd13,
      PH_RB_SCL_HI  = 5'd14,
      PH_RB_WAIT    = 5'd15,
      PH_RN_SCL_LO  = 5'd16,
      PH_RN_SDA     = 5'd17,
      PH_RN_SCL_HI  = 5'd18,
      PH_RN_SCL_LO2 = 5'd19,
      PH_SP_SDA_LO  = 5'd20,
      PH_SP_SCL_HI  = 5'd21,
      PH_SP_SDA_HI  = 5'd22,
      PH_FINISH     = 5'd23
   } phase_type;

   localparam logic [2:0] STEP_ADDR_W = 3'd0;
   localparam logic [2:0] STEP_REG    = 3'd1;
   localparam logic [2:0] STEP_RESTART = 3'd2;
   localparam logic [2:0] STEP_DONE   = 3'd3;
   localparam logic [2:0] STEP_FAILED = 3'd7;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   logic [DEV_ADDR_W-1:0] dev_addr_ff;
   logic [DELAY_W-1:0]    quarter_ff;
   logic [DELAY_W-1:0]    half_ff;

   phase_type          phase_ff, phase_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [3:0]         bit_ff, bit_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [2:0]         step_ff, step_in;
   logic               is_read_ff, is_read_in;
   logic [BYTE_W-1:0]  reg_ff, reg_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic               sda_drive_ff, sda_drive_in;
   logic               scl_drive_ff, scl_drive_in;

   logic               rsp_valid_ff;
   result_type         rsp_data_ff;
   result_type         result;
   logic               advance;

   function automatic logic [BYTE_W-1:0] load_value(
      input logic [2:0]            step,
      input logic                  rd,
      input logic [DEV_ADDR_W-1:0] dev,
      input logic [BYTE_W-1:0]     reg_a,
      input logic [BYTE_W-1:0]     data
   );
      logic [BYTE_W-1:0] value;
      case (step)
         STEP_ADDR_W: value = {dev, 1'b0};
         STEP_REG:    value = reg_a;
         default:     value = rd ? {dev, 1'b1} : data;
      endcase
      return value;
   endfunction

   assign advance    = item_valid && (!rsp_valid_ff || rsp.ready);
   assign item_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      phase_in     = phase_ff;
      delay_in     = delay_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      step_in      = step_ff;
      is_read_in   = is_read_ff;
      reg_in       = reg_ff;
      data_in      = data_ff;
      sda_drive_in = sda_drive_ff;
      scl_drive_in = scl_drive_ff;
      result       = '0;
      if (delay_ff != '0) begin
         delay_in = delay_ff - 1'b1;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               sda_drive_in = 1'b0;
               scl_drive_in = 1'b0;
               if (item.op != OP_TICK) begin
                  is_read_in = (item.op == OP_READ);
                  reg_in     = item.reg_addr;
                  data_in    = item.wr_data;
                  step_in    = STEP_ADDR_W;
                  phase_in   = PH_ST_SCL_HI;
               end
            end
            PH_ST_SCL_HI: begin
               scl_drive_in = 1'b0;
               phase_in     = PH_ST_SDA_LO;
               delay_in     = half_ff;
            end
            PH_ST_SDA_LO: begin
               sda_drive_in = 1'b1;
               shift_in     = load_value(step_ff, is_read_ff, dev_addr_ff, reg_ff, data_ff);
               bit_in       = '0;
               phase_in     = PH_WB_SCL_LO;
               delay_in     = half_ff;
            end
            PH_WB_SCL_LO: begin
               scl_drive_in = 1'b1;
               phase_in     = PH_WB_SDA;
               delay_in     = quarter_ff;
            end
            PH_WB_SDA: begin
               sda_drive_in = !shift_ff[BYTE_W-1];
               phase_in     = PH_WB_SCL_HI;
               delay_in     = half_ff;
            end
            PH_WB_SCL_HI: begin
               scl_drive_in = 1'b0;
               phase_in     = PH_WB_WAIT;
               delay_in     = half_ff;
            end
            PH_WB_WAIT: begin
               if (item.scl_in) begin
                  shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                  bit_in   = bit_ff + 1'b1;
                  phase_in = (bit_in >= BITS_PER_BYTE) ? PH_AK_SCL_LO : PH_WB_SCL_LO;
               end
            end
            PH_AK_SCL_LO: begin
               scl_drive_in = 1'b1;
               phase_in     = PH_AK_REL;
               delay_in     = quarter_ff;
            end
            PH_AK_REL: begin
               sda_drive_in = 1'b0;
               phase_in     = PH_AK_SCL_HI;
               delay_in     = half_ff;
            end
            PH_AK_SCL_HI: begin
               scl_drive_in = 1'b0;
               phase_in     = PH_AK_WAIT;
               delay_in     = half_ff;
            end
            PH_AK_WAIT: begin
               if (item.scl_in) begin
                  bit_in   = {3'b000, item.sda_in};
                  phase_in = PH_AK_END;
               end
            end
            PH_AK_END: begin
               scl_drive_in = 1'b1;
               delay_in     = half_ff;
               if (bit_ff != '0) begin
                  step_in  = STEP_FAILED;
                  phase_in = PH_SP_SDA_LO;
               end else begin
                  step_in = step_ff + 1'b1;
                  if (!is_read_ff) begin
                     if (step_in >= STEP_DONE) begin
                        phase_in = PH_SP_SDA_LO;
                     end else begin
                        shift_in = load_value(step_in, is_read_ff, dev_addr_ff, reg_ff,
                                              data_ff);
                        bit_in   = '0;
                        phase_in = PH_WB_SCL_LO;
                     end
                  end else if (step_in == STEP_REG) begin
                     shift_in = load_value(step_in, is_read_ff, dev_addr_ff, reg_ff, data_ff);
                     bit_in   = '0;
                     phase_in = PH_WB_SCL_LO;
                  end else if (step_in == STEP_RESTART) begin
                     phase_in = PH_ST_SCL_HI;
                  end else begin
                     bit_in   = '0;
                     shift_in = '0;
                     phase_in = PH_RB_SCL_LO;
                  end
               end
            end
            PH_RB_SCL_LO: begin
               scl_drive_in = 1'b1;
               phase_in     = PH_RB_SCL_HI;
               delay_in     = half_ff;
            end
            PH_RB_SCL_HI: begin
               scl_drive_in = 1'b0;
               phase_in     = PH_RB_WAIT;
               delay_in     = half_ff;
            end
            PH_RB_WAIT: begin
               if (item.scl_in) begin
                  shift_in = {shift_ff[BYTE_W-2:0], item.sda_in};
                  bit_in   = bit_ff + 1'b1;
                  phase_in = (bit_in >= BITS_PER_BYTE) ? PH_RN_SCL_LO : PH_RB_SCL_LO;
               end
            end
            PH_RN_SCL_LO: begin
               scl_drive_in = 1'b1;
               phase_in     = PH_RN_SDA;
               delay_in     = quarter_ff;
            end
            PH_RN_SDA: begin
               sda_drive_in = 1'b0;
               phase_in     = PH_RN_SCL_HI;
               delay_in     = half_ff;
            end
            PH_RN_SCL_HI: begin
               scl_drive_in = 1'b0;
               phase_in     = PH_RN_SCL_LO2;
               delay_in     = half_ff;
            end
            PH_RN_SCL_LO2: begin
               scl_drive_in = 1'b1;
               data_in      = shift_ff;
               phase_in     = PH_SP_SDA_LO;
               delay_in     = half_ff;
            end
            PH_SP_SDA_LO: begin
               sda_drive_in = 1'b1;
               phase_in     = PH_SP_SCL_HI;
               delay_in     = half_ff;
            end
            PH_SP_SCL_HI: begin
               scl_drive_in = 1'b0;
               phase_in     = PH_SP_SDA_HI;
               delay_in     = quarter_ff;
            end
            PH_SP_SDA_HI: begin
               sda_drive_in = 1'b0;
               phase_in     = PH_FINISH;
               delay_in     = half_ff;
            end
            PH_FINISH: begin
               result.done_res = 1'b1;
               result.success  = (step_ff != STEP_FAILED);
               result.read_byte = (result.success && is_read_ff) ? data_ff : '0;
               phase_in        = PH_IDLE;
            end
            default: begin
               sda_drive_in = 1'b0;
               scl_drive_in = 1'b0;
               phase_in     = PH_IDLE;
               delay_in     = '0;
            end
         endcase
      end
      result.sda_pull_low = sda_drive_in;
      result.scl_pull_low = scl_drive_in;
      result.busy_res     = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= DEVICE_ADDRESS_RST;
         quarter_ff   <= QUARTER_DELAY_RST;
         half_ff      <= HALF_DELAY_RST;
         phase_ff     <= PH_IDLE;
         delay_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         step_ff      <= '0;
         is_read_ff   <= 1'b0;
         reg_ff       <= '0;
         data_ff      <= '0;
         sda_drive_ff <= 1'b0;
         scl_drive_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_wdata[DEV_ADDR_W-1:0];
               CSR_QUARTER_DELAY:  quarter_ff  <= csr_wdata[DELAY_W-1:0];
               CSR_HALF_DELAY:     half_ff     <= csr_wdata[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (advance) begin
            phase_ff     <= phase_in;
            delay_ff     <= delay_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            step_ff      <= step_in;
            is_read_ff   <= is_read_in;
            reg_ff       <= reg_in;
            data_ff      <= data_in;
            sda_drive_ff <= sda_drive_in;
            scl_drive_ff <= scl_drive_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sda_pull_low = rsp_data_ff.sda_pull_low;
   assign rsp.scl_pull_low = rsp_data_ff.scl_pull_low;
   assign rsp.busy_res     = rsp_data_ff.busy_res;
   assign rsp.done_res     = rsp_data_ff.done_res;
   assign rsp.success      = rsp_data_ff.success;
   assign rsp.read_byte    = rsp_data_ff.read_byte;

endmodule

// ===== hw/rtl/i2c_register_access_master_unit.sv =====
// Open-drain I2C master that performs single-byte register reads and writes.
// Each item on req_bus is one bus tick: the sampled SDA and SCL levels and an
// optional command (read or write of one register), which is taken only when
// the bus engine is idle. For every item accepted exactly one item leaves on
// rsp_bus, carrying the pin drives, busy, done, success and the read byte.
// Configuration (device address, quarter and half bit delays) is written
// through csr_we, csr_index and csr_wdata while no items are in flight; the
// user keeps to this, the block does not enforce it. An accepted item passes
// an input register, a queue of QUEUE_DEPTH entries and the bus engine, whose
// output register presents the result. One item is taken every cycle while
// rsp_bus.ready is high; the engine steps its state machine once per item.
// Reset clears the queue and the engine, releases both lines and restores the
// configuration to address 0x68, quarter delay 12 and half delay 20.
// When the receiver holds rsp_bus.ready low the result is held, the engine
// stops, and the queue and input register fill; req_bus.ready then falls.
module i2c_register_access_master_unit import i2cram_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   i2cram_req_if.sink             req_bus,
   i2cram_rsp_if.source           rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   i2cram_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   i2cram_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   i2cram_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .rsp        (rsp_bus)
   );

endmodule

// ===== hw/rtl/i2cram_checker.sv =====
module i2cram_props_checker import i2cram_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              busy_res,
   input logic              done_res,
   input logic              success,
   input logic [BYTE_W-1:0] read_byte
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item dropped while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res)
      else $error("Transfer reported done while still busy.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && success |-> done_res)
      else $error("Success reported without done.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (read_byte != '0) |-> done_res && success)
      else $error("Read data shown outside a successful completion.");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("Result item present straight after reset.");

endmodule

bind i2c_register_access_master_unit i2cram_props_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .busy_res  (rsp_bus.busy_res),
   .done_res  (rsp_bus.done_res),
   .success   (rsp_bus.success),
   .read_byte (rsp_bus.read_byte)
);

// ===== sim/i2cram_checker.sv =====
`timescale 1ns / 100ps

module i2cram_checker import i2cram_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   i2cram_req_if                  req_mon,
   i2cram_rsp_if                  rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     transfers,
   output int                     acked_transfers
);

   localparam logic [2:0] STEP_FAILED   = 3'd7;
   localparam int         BITS_PER_BYTE = 8;
   localparam int         REPORT_LIMIT  = 40;

   typedef enum logic [4:0] {
      ST_IDLE         = 5'd0,
      ST_START_HI     = 5'd1,
      ST_START_LO     = 5'd2,
      ST_TX_CLK_LO    = 5'd4,
      ST_TX_DATA      = 5'd5,
      ST_TX_CLK_HI    = 5'd6,
      ST_TX_WAIT      = 5'd7,
      ST_ACK_CLK_LO   = 5'd8,
      ST_ACK_REL      = 5'd9,
      ST_ACK_CLK_HI   = 5'd10,
      ST_ACK_WAIT     = 5'd11,
      ST_ACK_END      = 5'd12,
      ST_RX_CLK_LO    = 5'd13,
      ST_RX_CLK_HI    = 5'd14,
      ST_RX_WAIT      = 5'd15,
      ST_NACK_CLK_LO  = 5'd16,
      ST_NACK_REL     = 5'd17,
      ST_NACK_CLK_HI  = 5'd18,
      ST_NACK_CLK_LO2 = 5'd19,
      ST_STOP_SDA_LO  = 5'd20,
      ST_STOP_CLK_HI  = 5'd21,
      ST_STOP_SDA_HI  = 5'd22,
      ST_FINISH       = 5'd23
   } bus_phase_type;

   logic [DEV_ADDR_W-1:0] dev_addr;
   logic [DELAY_W-1:0]    quarter_ticks;
   logic [DELAY_W-1:0]    half_ticks;

   bus_phase_type         eng_phase;
   logic [DELAY_W-1:0]    delay_left;
   logic [3:0]            bit_cnt;
   logic [BYTE_W-1:0]     shifter;
   logic [2:0]            byte_idx;
   logic                  read_op;
   logic [BYTE_W-1:0]     held_reg;
   logic [BYTE_W-1:0]     held_data;
   logic                  sda_drv;
   logic                  scl_drv;

   result_type            expected_results[$];
   int                    result_index;

   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LIMIT)
         $display("checker: result %0d: %s", result_index, msg);
      fail_count++;
   endtask

   task automatic reset_model();
      dev_addr      = DEVICE_ADDRESS_RST;
      quarter_ticks = QUARTER_DELAY_RST;
      half_ticks    = HALF_DELAY_RST;
      eng_phase     = ST_IDLE;
      delay_left    = '0;
      bit_cnt       = '0;
      shifter       = '0;
      byte_idx      = '0;
      read_op       = 1'b0;
      held_reg      = '0;
      held_data     = '0;
      sda_drv       = 1'b0;
      scl_drv       = 1'b0;
   endtask

   task automatic advance(input bus_phase_type nxt, input logic [DELAY_W-1:0] wait_ticks);
      eng_phase  = nxt;
      delay_left = wait_ticks;
   endtask

   task automatic load_frame();
      if (byte_idx == 3'd0) begin
         shifter = {dev_addr, 1'b0};
      end else if (byte_idx == 3'd1) begin
         shifter = held_reg;
      end else begin
         shifter = read_op ? {dev_addr, 1'b1} : held_data;
      end
      bit_cnt = '0;
   endtask

   task automatic step_engine(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] reg_a,
                              input logic [BYTE_W-1:0] wdat, input logic sda,
                              input logic scl, output result_type res);
      logic              done;
      logic              ok;
      logic [BYTE_W-1:0] rdata;
      done  = 1'b0;
      ok    = 1'b0;
      rdata = '0;
      if (delay_left != '0) begin
         delay_left = delay_left - 1'b1;
      end else begin
         case (eng_phase)
            ST_IDLE: begin
               sda_drv = 1'b0;
               scl_drv = 1'b0;
               if (cmd == CMD_READ || cmd == CMD_WRITE) begin
                  read_op   = (cmd == CMD_READ);
                  held_reg  = reg_a;
                  held_data = wdat;
                  byte_idx  = '0;
                  advance(ST_START_HI, '0);
               end
            end
            ST_START_HI: begin
               scl_drv = 1'b0;
               advance(ST_START_LO, half_ticks);
            end
            ST_START_LO: begin
               sda_drv = 1'b1;
               load_frame();
               advance(ST_TX_CLK_LO, half_ticks);
            end
            ST_TX_CLK_LO: begin
               scl_drv = 1'b1;
               advance(ST_TX_DATA, quarter_ticks);
            end
            ST_TX_DATA: begin
               sda_drv = ~shifter[BYTE_W-1];
               advance(ST_TX_CLK_HI, half_ticks);
            end
            ST_TX_CLK_HI: begin
               scl_drv = 1'b0;
               advance(ST_TX_WAIT, half_ticks);
            end
            ST_TX_WAIT: begin
               if (scl) begin
                  shifter = {shifter[BYTE_W-2:0], 1'b0};
                  bit_cnt = bit_cnt + 1'b1;
                  advance(bit_cnt >= BITS_PER_BYTE ? ST_ACK_CLK_LO : ST_TX_CLK_LO, '0);
               end
            end
            ST_ACK_CLK_LO: begin
               scl_drv = 1'b1;
               advance(ST_ACK_REL, quarter_ticks);
            end
            ST_ACK_REL: begin
               sda_drv = 1'b0;
               advance(ST_ACK_CLK_HI, half_ticks);
            end
            ST_ACK_CLK_HI: begin
               scl_drv = 1'b0;
               advance(ST_ACK_WAIT, half_ticks);
            end
            ST_ACK_WAIT: begin
               // The bit counter is reused to hold the acknowledge level.
               if (scl) begin
                  bit_cnt = {3'd0, sda};
                  advance(ST_ACK_END, '0);
               end
            end
            ST_ACK_END: begin
               scl_drv = 1'b1;
               if (bit_cnt != '0) begin
                  byte_idx = STEP_FAILED;
                  advance(ST_STOP_SDA_LO, half_ticks);
               end else begin
                  byte_idx = byte_idx + 3'd1;
                  if (!read_op) begin
                     if (byte_idx >= 3'd3) begin
                        advance(ST_STOP_SDA_LO, half_ticks);
                     end else begin
                        load_frame();
                        advance(ST_TX_CLK_LO, half_ticks);
                     end
                  end else if (byte_idx == 3'd1) begin
                     load_frame();
                     advance(ST_TX_CLK_LO, half_ticks);
                  end else if (byte_idx == 3'd2) begin
                     advance(ST_START_HI, half_ticks);
                  end else begin
                     bit_cnt = '0;
                     shifter = '0;
                     advance(ST_RX_CLK_LO, half_ticks);
                  end
               end
            end
            ST_RX_CLK_LO: begin
               scl_drv = 1'b1;
               advance(ST_RX_CLK_HI, half_ticks);
            end
            ST_RX_CLK_HI: begin
               scl_drv = 1'b0;
               advance(ST_RX_WAIT, half_ticks);
            end
            ST_RX_WAIT: begin
               if (scl) begin
                  shifter = {shifter[BYTE_W-2:0], sda};
                  bit_cnt = bit_cnt + 1'b1;
                  advance(bit_cnt >= BITS_PER_BYTE ? ST_NACK_CLK_LO : ST_RX_CLK_LO, '0);
               end
            end
            ST_NACK_CLK_LO: begin
               scl_drv = 1'b1;
               advance(ST_NACK_REL, quarter_ticks);
            end
            ST_NACK_REL: begin
               sda_drv = 1'b0;
               advance(ST_NACK_CLK_HI, half_ticks);
            end
            ST_NACK_CLK_HI: begin
               scl_drv = 1'b0;
               advance(ST_NACK_CLK_LO2, half_ticks);
            end
            ST_NACK_CLK_LO2: begin
               scl_drv   = 1'b1;
               held_data = shifter;
               advance(ST_STOP_SDA_LO, half_ticks);
            end
            ST_STOP_SDA_LO: begin
               sda_drv = 1'b1;
               advance(ST_STOP_CLK_HI, half_ticks);
            end
            ST_STOP_CLK_HI: begin
               scl_drv = 1'b0;
               advance(ST_STOP_SDA_HI, quarter_ticks);
            end
            ST_STOP_SDA_HI: begin
               sda_drv = 1'b0;
               advance(ST_FINISH, half_ticks);
            end
            ST_FINISH: begin
               done  = 1'b1;
               ok    = (byte_idx != STEP_FAILED);
               rdata = (ok && read_op) ? held_data : '0;
               advance(ST_IDLE, '0);
            end
            default: begin
               sda_drv = 1'b0;
               scl_drv = 1'b0;
               advance(ST_IDLE, '0);
            end
         endcase
      end
      res.sda_pull_low = sda_drv;
      res.scl_pull_low = scl_drv;
      res.busy_res     = (eng_phase != ST_IDLE);
      res.done_res     = done;
      res.success      = ok;
      res.read_byte    = rdata;
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         reset_model();
         expected_results.delete();
         result_index    = 0;
         fail_count      = 0;
         transfers       = 0;
         acked_transfers = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEVICE_ADDRESS: dev_addr      = csr_wdata[DEV_ADDR_W-1:0];
               CSR_QUARTER_DELAY:  quarter_ticks = csr_wdata[DELAY_W-1:0];
               CSR_HALF_DELAY:     half_ticks    = csr_wdata[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            step_engine(req_mon.cmd, req_mon.reg_addr, req_mon.wr_data,
                        req_mon.sda_in, req_mon.scl_in, want);
            expected_results.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.sda_pull_low = rsp_mon.sda_pull_low;
            got.scl_pull_low = rsp_mon.scl_pull_low;
            got.busy_res     = rsp_mon.busy_res;
            got.done_res     = rsp_mon.done_res;
            got.success      = rsp_mon.success;
            got.read_byte    = rsp_mon.read_byte;
            if (expected_results.size() == 0) begin
               report_mismatch("item arrived with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (got.sda_pull_low !== want.sda_pull_low)
                  report_mismatch($sformatf("sda_pull_low %0b, expected %0b",
                                            got.sda_pull_low, want.sda_pull_low));
               if (got.scl_pull_low !== want.scl_pull_low)
                  report_mismatch($sformatf("scl_pull_low %0b, expected %0b",
                                            got.scl_pull_low, want.scl_pull_low));
               if (got.busy_res !== want.busy_res)
                  report_mismatch($sformatf("busy_res %0b, expected %0b",
                                            got.busy_res, want.busy_res));
               if (got.done_res !== want.done_res)
                  report_mismatch($sformatf("done_res %0b, expected %0b",
                                            got.done_res, want.done_res));
               if (got.success !== want.success)
                  report_mismatch($sformatf("success %0b, expected %0b",
                                            got.success, want.success));
               if (got.read_byte !== want.read_byte)
                  report_mismatch($sformatf("read_byte %02h, expected %02h",
                                            got.read_byte, want.read_byte));
            end
            if (got.done_res === 1'b1) begin
               transfers++;
               if (got.success === 1'b1)
                  acked_transfers++;
            end
            result_index++;
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== sim/i2c_register_access_master_unit_tb.sv =====
`timescale 1ns / 100ps

module i2c_register_access_master_unit_tb import i2cram_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
   localparam int               TAIL_CYCLES = 16;
   localparam int               CYCLE_LIMIT = 200000;
   localparam int               PHASE_ITEMS = 160;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int fail_count;
   int pending;
   int transfers;
   int acked_transfers;
   int gap_pct     = 0;
   int stall_pct   = 0;
   int items_sent  = 0;
   int cycle_count = 0;

   i2cram_req_if req_bus ();
   i2cram_rsp_if rsp_bus ();

   i2c_register_access_master_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2cram_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .transfers       (transfers),
      .acked_transfers (acked_transfers)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] reg_a,
                            input logic [BYTE_W-1:0] wdat, input logic sda, input logic scl);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.reg_addr <= reg_a;
      req_bus.wr_data  <= wdat;
      req_bus.sda_in   <= sda;
      req_bus.scl_in   <= scl;
      do
         @(posedge clock);
      while (!req_bus.ready);
      items_sent++;
   endtask

   // Most stretches act as a slave that acknowledges; some carry noisy SDA
   // and frequent clock stretching, which leads to NACK aborts.
   task automatic send_random(input int count);
      int                n;
      int                pick;
      int                sda_low_pct;
      int                scl_high_pct;
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] reg_a;
      logic [BYTE_W-1:0] wdat;
      sda_low_pct  = 92;
      scl_high_pct = 90;
      for (n = 0; n < count; n++) begin
         if (n % 32 == 0) begin
            sda_low_pct  = ($urandom_range(3) == 0) ? 50 : 92;
            scl_high_pct = ($urandom_range(3) == 0) ? 55 : 90;
         end
         pick = $urandom_range(99);
         if (pick < 7)
            cmd = CMD_READ;
         else if (pick < 14)
            cmd = CMD_WRITE;
         else if (pick < 18)
            cmd = CMD_UNUSED;
         else
            cmd = CMD_TICK;
         reg_a = $urandom_range(255);
         wdat  = $urandom_range(255);
         send_item(cmd, reg_a, wdat, $urandom_range(99) >= sda_low_pct,
                   $urandom_range(99) < scl_high_pct);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [DEV_ADDR_W-1:0] dev, input logic [DELAY_W-1:0] quarter,
                               input logic [DELAY_W-1:0] half);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEVICE_ADDRESS;
      csr_wdata <= CSR_DATA_W'(dev);
      @(negedge clock);
      csr_index <= CSR_QUARTER_DELAY;
      csr_wdata <= quarter;
      @(negedge clock);
      csr_index <= CSR_HALF_DELAY;
      csr_wdata <= half;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int k;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_DEVICE_ADDRESS;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_TICK;
      req_bus.reg_addr = '0;
      req_bus.wr_data  = '0;
      req_bus.sda_in   = 1'b1;
      req_bus.scl_in   = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: an unused command while idle, a write with extreme
      // fields, then requests that arrive while the engine is busy.
      send_item(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1);
      send_item(CMD_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
      send_item(CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1);
      send_item(CMD_READ, 8'h00, 8'hFF, 1'b1, 1'b1);
      send_item(CMD_WRITE, 8'h00, 8'hFF, 1'b1, 1'b0);
      send_item(CMD_UNUSED, 8'hA5, 8'h5A, 1'b0, 1'b0);
      for (k = 0; k < 16; k++)
         send_item(CMD_TICK, 8'(k * 17), 8'(~(k * 17)), k[0], k[1]);
      drain();

      program_regs(7'd0, 16'd0, 16'd0);
      gap_pct   = 0;
      stall_pct = 0;
      send_random(PHASE_ITEMS);
      drain();

      program_regs(7'd127, 16'd1, 16'd0);
      gap_pct   = 66;
      stall_pct = 0;
      send_random(PHASE_ITEMS);
      drain();

      program_regs(DEV_ADDR_W'($urandom_range(127)), 16'd0, 16'd1);
      gap_pct   = 0;
      stall_pct = 66;
      send_random(PHASE_ITEMS);
      drain();

      program_regs(DEV_ADDR_W'($urandom_range(127)), 16'd0, 16'd0);
      gap_pct   = 38;
      stall_pct = 38;
      send_random(PHASE_ITEMS);
      drain();

      program_regs(DEV_ADDR_W'($urandom_range(127)), 16'hFFFF, 16'hFFFF);
      send_random(40);
      drain();

      $display("summary: %0d items over six register settings with sender gaps and stalls,",
               items_sent);
      $display("summary: %0d transfers ended, %0d fully acknowledged, %0d mismatches",
               transfers, acked_transfers, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
